// ===== design/ufp_pkg.sv =====
// Shared types, character constants and the hex digit helper for the
// form-urlencoded parser. No dependencies.
package ufp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    MODE_NAME  = 2'd0,
    MODE_VALUE = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NAME_BYTE    = 3'd0,
    KIND_NAME_DISCARD = 3'd1,
    KIND_NAME_DONE    = 3'd2,
    KIND_VALUE_BYTE   = 3'd3,
    KIND_PAIR_END     = 3'd4,
    KIND_FORM_END     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    CLS_END   = 3'd0,
    CLS_AMP   = 3'd1,
    CLS_EQ    = 3'd2,
    CLS_PLUS  = 3'd3,
    CLS_PCT   = 3'd4,
    CLS_CR    = 3'd5,
    CLS_OTHER = 3'd6
  } cls_t;

  // One classified input byte as it sits in the queue.
  typedef struct packed {
    cls_t       cls;
    logic [3:0] nibble;
    logic [7:0] raw;
  } item_t;

  // Lenient hex digit: anything that is not a hex character reads as 0.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== design/urlencoded_form_parser.sv =====
// Top level of the form-urlencoded parser: front classifier, queue, back
// parser. Depends on ufp_pkg, ufp_front, ufp_queue and ufp_back.
//
// Takes one byte of a form body per beat and returns at most one token per
// byte: name bytes, name discarded, name complete, decoded value bytes,
// pair end and form end (a zero byte, which also returns to name mode).
// '+' in a value decodes to a space, %xx decodes leniently (non-hex digits
// read as 0), and carriage returns in values are dropped. Throughput is one
// byte per clock while the output is not stalled. An accepted byte passes
// through the queue stage and then the output register of the back end
// before its token can be taken. The front end classifies each byte and
// fills a QUEUE_DEPTH-entry register queue; the back end runs the mode
// machine and pops one entry per clock whenever its output register is
// empty or being taken. A byte that yields no token (a '%', the first
// escape digit, a dropped carriage return) still takes a pop from the
// queue. in_stall rises only when the queue is full, so a stalled output
// absorbs QUEUE_DEPTH more bytes.
module urlencoded_form_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] token_kind,
  output logic [7:0] token_byte
);
  import ufp_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  // Classify and accept.
  ufp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // Decouples input acceptance from output stalls.
  ufp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Mode machine, escape decode and output register.
  ufp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_kind (token_kind),
    .token_byte (token_byte)
  );

endmodule

// ===== design/ufp_front.sv =====
// Front end: accepts input beats and classifies each byte.
// Depends on ufp_pkg.
module ufp_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  output logic          push,
  output ufp_pkg::item_t push_item,
  input  logic          q_full
);
  import ufp_pkg::*;

  cls_t cls;

  always_comb begin
    case (in_byte)
      CH_NUL:  cls = CLS_END;
      CH_AMP:  cls = CLS_AMP;
      CH_EQ:   cls = CLS_EQ;
      CH_PLUS: cls = CLS_PLUS;
      CH_PCT:  cls = CLS_PCT;
      CH_CR:   cls = CLS_CR;
      default: cls = CLS_OTHER;
    endcase
  end

  assign in_stall         = q_full;
  assign push             = in_valid && !q_full;
  assign push_item.cls    = cls;
  assign push_item.nibble = hex_value(in_byte);
  assign push_item.raw    = in_byte;

endmodule

// ===== design/ufp_queue.sv =====
// Short register FIFO of classified bytes between front and back.
// Depends on ufp_pkg.
module ufp_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ufp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output ufp_pkg::item_t q_item
);
  import ufp_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         slots [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_COUNT);
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/ufp_back.sv =====
// Back end: parse mode machine and the registered token output.
// Depends on ufp_pkg.
module ufp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ufp_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     token_kind,
  output logic [7:0]     token_byte
);
  import ufp_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       emit;
  kind_t      emit_kind;
  logic [7:0] emit_byte;
  logic [7:0] decoded;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = q_valid && out_free;
  assign decoded  = {high_nibble, q_item.nibble};

  // Next mode and held nibble.
  always_comb begin
    mode_next        = mode;
    high_nibble_next = high_nibble;
    if (q_item.cls == CLS_END) begin
      mode_next        = MODE_NAME;
      high_nibble_next = 4'd0;
    end else begin
      case (mode)
        MODE_NAME: begin
          if (q_item.cls == CLS_EQ) mode_next = MODE_VALUE;
        end
        MODE_VALUE: begin
          if (q_item.cls == CLS_AMP) begin
            mode_next = MODE_NAME;
          end else if (q_item.cls == CLS_PCT) begin
            mode_next = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          high_nibble_next = q_item.nibble;
          mode_next        = MODE_HEX2;
        end
        MODE_HEX2: mode_next = MODE_VALUE;
        default:   mode_next = MODE_NAME;
      endcase
    end
  end

  // Token for the current byte, if any.
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_FORM_END;
    emit_byte = 8'd0;
    if (q_item.cls == CLS_END) begin
      emit = 1'b1;
    end else begin
      case (mode)
        MODE_NAME: begin
          emit = 1'b1;
          if (q_item.cls == CLS_AMP) begin
            emit_kind = KIND_NAME_DISCARD;
          end else if (q_item.cls == CLS_EQ) begin
            emit_kind = KIND_NAME_DONE;
          end else begin
            emit_kind = KIND_NAME_BYTE;
            emit_byte = q_item.raw;
          end
        end
        MODE_VALUE: begin
          if (q_item.cls == CLS_AMP) begin
            emit      = 1'b1;
            emit_kind = KIND_PAIR_END;
          end else if (q_item.cls == CLS_PLUS) begin
            emit      = 1'b1;
            emit_kind = KIND_VALUE_BYTE;
            emit_byte = CH_SPACE;
          end else if (q_item.cls != CLS_PCT && q_item.cls != CLS_CR) begin
            emit      = 1'b1;
            emit_kind = KIND_VALUE_BYTE;
            emit_byte = q_item.raw;
          end
        end
        MODE_HEX1: emit = 1'b0;
        MODE_HEX2: begin
          emit      = (decoded != CH_CR);
          emit_kind = KIND_VALUE_BYTE;
          emit_byte = decoded;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NAME;
      high_nibble <= 4'd0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        mode        <= mode_next;
        high_nibble <= high_nibble_next;
      end
      if (out_free) begin
        out_valid <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      token_kind <= emit_kind;
      token_byte <= emit_byte;
    end
  end

endmodule
